>>> design/cv3_pkg.sv
package cv3_pkg;

   localparam int IMAGE_WIDTH  = 58;
   localparam int IMAGE_HEIGHT = 58;
   localparam int DATA_BITS    = 16;
   localparam int LANES        = 2;
   localparam int TAPS         = 9;
   localparam int COEF_COUNT   = LANES * TAPS;

   localparam int CMD_BITS     = 1;
   localparam int WIDX_BITS    = 5;
   localparam int POS_BITS     = 6;
   localparam int SUM_BITS     = 41;

   localparam int COL_BITS     = $clog2(IMAGE_WIDTH);
   localparam int ROW_BITS     = $clog2(IMAGE_HEIGHT);

   // product, sum of three products, sum of all partials
   localparam int PROD_BITS    = 2 * DATA_BITS;
   localparam int PART_BITS    = PROD_BITS + 2;
   localparam int PARTS        = LANES * (TAPS / 3);
   localparam int TOTAL_BITS   = PART_BITS + $clog2(PARTS) + 1;

   localparam logic [CMD_BITS-1:0] CMD_WEIGHT = 1'b0;
   localparam logic [CMD_BITS-1:0] CMD_PIXEL  = 1'b1;

   // one line store entry: per lane the top row and the middle row pixel
   typedef logic [LANES-1:0][1:0][DATA_BITS-1:0] line_word_type;

   typedef struct packed {
      logic [POS_BITS-1:0] out_row;
      logic [POS_BITS-1:0] out_col;
      logic                last;
   } tag_type;

endpackage

>>> design/cv3_req_if.sv
interface cv3_req_if;
   logic                                    valid;
   logic                                    ready;
   logic [cv3_pkg::CMD_BITS-1:0]            command;
   logic [cv3_pkg::WIDX_BITS-1:0]           weight_index;
   logic signed [cv3_pkg::DATA_BITS-1:0]    weight_value;
   logic signed [cv3_pkg::DATA_BITS-1:0]    pixel_lane0;
   logic signed [cv3_pkg::DATA_BITS-1:0]    pixel_lane1;

   modport source (
      output valid, command, weight_index, weight_value, pixel_lane0, pixel_lane1,
      input  ready
   );
   modport sink (
      input  valid, command, weight_index, weight_value, pixel_lane0, pixel_lane1,
      output ready
   );
endinterface

>>> design/cv3_rsp_if.sv
interface cv3_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [cv3_pkg::SUM_BITS-1:0]  conv_sum;
   logic [cv3_pkg::POS_BITS-1:0]         out_row;
   logic [cv3_pkg::POS_BITS-1:0]         out_col;
   logic                                 last;

   modport source (
      output valid, conv_sum, out_row, out_col, last,
      input  ready
   );
   modport sink (
      input  valid, conv_sum, out_row, out_col, last,
      output ready
   );
endinterface

>>> design/conv3x3_line_buffer_engine_unit.sv
// 3x3 valid-mode convolution over two pixel lanes, raster-order stream.
// req channel: command selects a weight load (weight_index, weight_value) or a
// pixel item (pixel_lane0, pixel_lane1). Weight indexes of 18 and above are
// dropped. A new weight is used by every sum of a pixel item accepted after it.
// rsp channel: one item per pixel at row >= 2 and column >= 2, carrying the
// sum of 18 products, the output row and column and last on the image's final
// position. Border pixels and weight loads give no result.
// Steps: window update, 18 multipliers, partial sums, then final sum into the
// output register, each a registered stage. Throughput: one item per cycle while
// the receiver takes results; the line store has one read each cycle and one write
// per accepted pixel, read one column ahead and written at the current column.
// Each stage holds its item only while the stage behind it is full, so a
// stalled receiver blocks req only once all four stages hold items.
// Reset clears coefficients, the windows, the counters and all stage valids;
// the line store keeps whatever it held, and the first two rows of every
// image refill it before any result depends on it.
module conv3x3_line_buffer_engine_unit (
   input logic       clock,
   input logic       reset,
   cv3_req_if.sink   req,
   cv3_rsp_if.source rsp
);

   localparam int W = cv3_pkg::IMAGE_WIDTH;
   localparam int H = cv3_pkg::IMAGE_HEIGHT;
   localparam int L = cv3_pkg::LANES;
   localparam int T = cv3_pkg::TAPS;
   localparam int D = cv3_pkg::DATA_BITS;

   // counters and line store
   logic [cv3_pkg::COL_BITS-1:0] col_ff, col_in;
   logic [cv3_pkg::ROW_BITS-1:0] row_ff, row_in;
   cv3_pkg::line_word_type       line_mem [W];
   cv3_pkg::line_word_type       rd_word_ff;
   cv3_pkg::line_word_type       wr_word;

   logic signed [D-1:0] coef_ff   [cv3_pkg::COEF_COUNT];
   logic signed [D-1:0] window_ff [L][T];
   logic signed [D-1:0] pix       [L];

   // pipeline
   logic                                  s1_v_ff, s2_v_ff, s3_v_ff, out_v_ff;
   cv3_pkg::tag_type                      s1_tag_ff, s2_tag_ff, s3_tag_ff, out_tag_ff;
   logic signed [cv3_pkg::PROD_BITS-1:0]  prod_ff [L][T];
   logic signed [cv3_pkg::PART_BITS-1:0]  part_ff [cv3_pkg::PARTS];
   logic signed [cv3_pkg::PART_BITS-1:0]  part_in [cv3_pkg::PARTS];
   logic signed [cv3_pkg::TOTAL_BITS-1:0] total_in;
   logic signed [cv3_pkg::SUM_BITS-1:0]   sum_ff;

   logic out_move, s3_move, s2_move, s1_move;
   logic accept, pix_accept, wgt_accept, emit;

   assign out_move = !out_v_ff || rsp.ready;
   assign s3_move  = !s3_v_ff || out_move;
   assign s2_move  = !s2_v_ff || s3_move;
   assign s1_move  = !s1_v_ff || s2_move;

   assign req.ready  = s1_move;
   assign accept     = req.valid && s1_move;
   assign pix_accept = accept && (req.command == cv3_pkg::CMD_PIXEL);
   assign wgt_accept = accept && (req.command == cv3_pkg::CMD_WEIGHT);

   assign pix[0] = req.pixel_lane0;
   assign pix[1] = req.pixel_lane1;

   assign emit = (row_ff >= cv3_pkg::ROW_BITS'(2)) && (col_ff >= cv3_pkg::COL_BITS'(2));

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (pix_accept) begin
         if (col_ff == cv3_pkg::COL_BITS'(W - 1)) begin
            col_in = '0;
            if (row_ff == cv3_pkg::ROW_BITS'(H - 1)) begin
               row_in = '0;
            end else begin
               row_in = row_ff + 1'b1;
            end
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
      if (reset) begin
         col_in = '0;
         row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      col_ff <= col_in;
      row_ff <= row_in;
   end

   // new entry: middle row moves up, the incoming pixel becomes the middle row
   always_comb begin
      for (int l = 0; l < L; l++) begin
         wr_word[l][1] = rd_word_ff[l][0];
         wr_word[l][0] = pix[l];
      end
   end

   // read one column ahead, so the entry is ready when its pixel arrives
   always_ff @(posedge clock) begin
      rd_word_ff <= line_mem[col_in];
      if (pix_accept) begin
         line_mem[col_ff] <= wr_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < cv3_pkg::COEF_COUNT; i++) begin
            coef_ff[i] <= '0;
         end
      end else if (wgt_accept && (req.weight_index < cv3_pkg::WIDX_BITS'(cv3_pkg::COEF_COUNT)))
      begin
         coef_ff[req.weight_index] <= req.weight_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < L; l++) begin
            for (int k = 0; k < T; k++) begin
               window_ff[l][k] <= '0;
            end
         end
      end else if (pix_accept) begin
         for (int l = 0; l < L; l++) begin
            for (int r = 0; r < 3; r++) begin
               window_ff[l][r*3]   <= window_ff[l][r*3+1];
               window_ff[l][r*3+1] <= window_ff[l][r*3+2];
            end
            window_ff[l][2] <= signed'(rd_word_ff[l][1]);
            window_ff[l][5] <= signed'(rd_word_ff[l][0]);
            window_ff[l][8] <= pix[l];
         end
      end
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (s1_move) begin
            s1_v_ff <= pix_accept && emit;
         end
         if (s2_move) begin
            s2_v_ff <= s1_v_ff;
         end
         if (s3_move) begin
            s3_v_ff <= s2_v_ff;
         end
         if (out_move) begin
            out_v_ff <= s3_v_ff;
         end
      end
   end

   always_comb begin
      for (int p = 0; p < cv3_pkg::PARTS; p++) begin
         part_in[p] = '0;
         for (int j = 0; j < 3; j++) begin
            part_in[p] = part_in[p] + cv3_pkg::PART_BITS'(prod_ff[p/3][(p%3)*3+j]);
         end
      end
      total_in = '0;
      for (int p = 0; p < cv3_pkg::PARTS; p++) begin
         total_in = total_in + cv3_pkg::TOTAL_BITS'(part_ff[p]);
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (s1_move) begin
         s1_tag_ff.out_row <= cv3_pkg::POS_BITS'(row_ff - cv3_pkg::ROW_BITS'(2));
         s1_tag_ff.out_col <= cv3_pkg::POS_BITS'(col_ff - cv3_pkg::COL_BITS'(2));
         s1_tag_ff.last    <= (row_ff == cv3_pkg::ROW_BITS'(H - 1)) &&
                              (col_ff == cv3_pkg::COL_BITS'(W - 1));
      end
      if (s2_move) begin
         s2_tag_ff <= s1_tag_ff;
         for (int l = 0; l < L; l++) begin
            for (int k = 0; k < T; k++) begin
               prod_ff[l][k] <= coef_ff[l*T+k] * window_ff[l][k];
            end
         end
      end
      if (s3_move) begin
         s3_tag_ff <= s2_tag_ff;
         for (int p = 0; p < cv3_pkg::PARTS; p++) begin
            part_ff[p] <= part_in[p];
         end
      end
      if (out_move) begin
         out_tag_ff <= s3_tag_ff;
         sum_ff     <= cv3_pkg::SUM_BITS'(total_in);
      end
   end

   assign rsp.valid    = out_v_ff;
   assign rsp.conv_sum = sum_ff;
   assign rsp.out_row  = out_tag_ff.out_row;
   assign rsp.out_col  = out_tag_ff.out_col;
   assign rsp.last     = out_tag_ff.last;

   // border pixels never enter the pipeline
   a_border_no_emit: assert property (@(posedge clock) disable iff (reset)
      (pix_accept && (row_ff < cv3_pkg::ROW_BITS'(2))) |=> !s1_v_ff)
      else $error("border pixel entered the sum pipeline");

   // input is held back only when every stage holds an item
   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> (s1_v_ff && s2_v_ff && s3_v_ff && out_v_ff && !rsp.ready))
      else $error("input stalled with a free stage");

   a_counters_range: assert property (@(posedge clock) disable iff (reset)
      (col_ff < cv3_pkg::COL_BITS'(W)) && (row_ff < cv3_pkg::ROW_BITS'(H)))
      else $error("position counter out of range");

   a_weight_keeps_pos: assert property (@(posedge clock) disable iff (reset)
      wgt_accept |=> ($stable(col_ff) && $stable(row_ff)))
      else $error("weight item moved the position counters");

   a_last_position: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.last) |->
         ((rsp.out_row == cv3_pkg::POS_BITS'(H - 3)) &&
          (rsp.out_col == cv3_pkg::POS_BITS'(W - 3))))
      else $error("last flag on a position other than the final one");

endmodule

>>> tb/tb_conv3x3_line_buffer_engine_unit.sv
module tb_conv3x3_line_buffer_engine_unit;

   localparam int CYCLE_LIMIT = 400000;
   localparam int IDLE_PCT    = 27;

   typedef struct {
      logic signed [cv3_pkg::SUM_BITS-1:0] conv_sum;
      logic [cv3_pkg::POS_BITS-1:0]        out_row;
      logic [cv3_pkg::POS_BITS-1:0]        out_col;
      logic                                last;
   } conv_result_type;

   logic clock;
   logic reset;

   cv3_req_if req_bus ();
   cv3_rsp_if rsp_bus ();

   conv3x3_line_buffer_engine_unit u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   // predictor state
   logic signed [cv3_pkg::DATA_BITS-1:0] coef_mem [cv3_pkg::COEF_COUNT];
   logic signed [cv3_pkg::DATA_BITS-1:0] line_mem [2*cv3_pkg::IMAGE_WIDTH][cv3_pkg::LANES];
   logic signed [cv3_pkg::DATA_BITS-1:0] win_mem  [cv3_pkg::LANES][cv3_pkg::TAPS];
   int unsigned                          col_pos;
   int unsigned                          row_pos;

   conv_result_type pending_sums [$];

   int  cycle_count;
   int  mismatch_count;
   int  sums_checked;
   int  items_sent;
   int  pixels_sent;
   int  weights_sent;
   int  stall_left;
   bit  sender_steady;
   bit  receiver_steady;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void clear_predictor();
      foreach (coef_mem[i]) coef_mem[i] = '0;
      foreach (line_mem[i, j]) line_mem[i][j] = '0;
      foreach (win_mem[i, j]) win_mem[i][j] = '0;
      col_pos = 0;
      row_pos = 0;
   endfunction

   // store a weight load, or shift one pixel pair through the line store and windows and queue the sum if one is due
   function automatic void predict_conv_step(
         input logic [cv3_pkg::CMD_BITS-1:0]         cmd,
         input logic [cv3_pkg::WIDX_BITS-1:0]        widx,
         input logic signed [cv3_pkg::DATA_BITS-1:0] wval,
         input logic signed [cv3_pkg::DATA_BITS-1:0] p0,
         input logic signed [cv3_pkg::DATA_BITS-1:0] p1);
      logic signed [cv3_pkg::DATA_BITS-1:0] pix [cv3_pkg::LANES];
      logic signed [cv3_pkg::DATA_BITS-1:0] top;
      logic signed [cv3_pkg::DATA_BITS-1:0] mid;
      longint                               acc;
      conv_result_type                      res;
      if (cmd == cv3_pkg::CMD_WEIGHT) begin
         if (widx < cv3_pkg::COEF_COUNT) coef_mem[widx] = wval;
         return;
      end
      pix[0] = p0;
      pix[1] = p1;
      for (int lane = 0; lane < cv3_pkg::LANES; lane++) begin
         top = line_mem[col_pos][lane];
         mid = line_mem[cv3_pkg::IMAGE_WIDTH + col_pos][lane];
         line_mem[col_pos][lane] = mid;
         line_mem[cv3_pkg::IMAGE_WIDTH + col_pos][lane] = pix[lane];
         for (int k = 0; k < 3; k++) begin
            win_mem[lane][k*3]     = win_mem[lane][k*3 + 1];
            win_mem[lane][k*3 + 1] = win_mem[lane][k*3 + 2];
         end
         win_mem[lane][2] = top;
         win_mem[lane][5] = mid;
         win_mem[lane][8] = pix[lane];
      end
      if (row_pos >= 2 && col_pos >= 2) begin
         acc = 0;
         for (int lane = 0; lane < cv3_pkg::LANES; lane++)
            for (int k = 0; k < cv3_pkg::TAPS; k++)
               acc += longint'(coef_mem[lane*cv3_pkg::TAPS + k]) *
                      longint'(win_mem[lane][k]);
         res.conv_sum = acc[cv3_pkg::SUM_BITS-1:0];
         res.out_row  = cv3_pkg::POS_BITS'(row_pos - 2);
         res.out_col  = cv3_pkg::POS_BITS'(col_pos - 2);
         res.last     = (row_pos == cv3_pkg::IMAGE_HEIGHT - 1) &&
                        (col_pos == cv3_pkg::IMAGE_WIDTH - 1);
         pending_sums.push_back(res);
      end
      col_pos++;
      if (col_pos >= cv3_pkg::IMAGE_WIDTH) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= cv3_pkg::IMAGE_HEIGHT) begin
            row_pos = 0;
         end
      end
   endfunction

   // mostly full range, with the extremes and zero drawn often
   function automatic logic signed [cv3_pkg::DATA_BITS-1:0] draw_sample();
      int pick;
      pick = $urandom_range(0, 15);
      if (pick < 2) return {1'b1, {(cv3_pkg::DATA_BITS-1){1'b0}}};
      if (pick < 4) return {1'b0, {(cv3_pkg::DATA_BITS-1){1'b1}}};
      if (pick == 4) return '0;
      return cv3_pkg::DATA_BITS'($urandom);
   endfunction

   task automatic send_item(input logic [cv3_pkg::CMD_BITS-1:0]         cmd,
                            input logic [cv3_pkg::WIDX_BITS-1:0]        widx,
                            input logic signed [cv3_pkg::DATA_BITS-1:0] wval,
                            input logic signed [cv3_pkg::DATA_BITS-1:0] p0,
                            input logic signed [cv3_pkg::DATA_BITS-1:0] p1);
      @(negedge clock);
      while (!sender_steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.command      <= cmd;
      req_bus.weight_index <= widx;
      req_bus.weight_value <= wval;
      req_bus.pixel_lane0  <= p0;
      req_bus.pixel_lane1  <= p1;
      do @(posedge clock); while (!req_bus.ready);
      predict_conv_step(cmd, widx, wval, p0, p1);
      items_sent++;
      if (cmd == cv3_pkg::CMD_PIXEL) pixels_sent++;
      else weights_sent++;
   endtask

   task automatic send_pixel(input logic signed [cv3_pkg::DATA_BITS-1:0] p0,
                             input logic signed [cv3_pkg::DATA_BITS-1:0] p1);
      send_item(cv3_pkg::CMD_PIXEL, cv3_pkg::WIDX_BITS'($urandom),
                cv3_pkg::DATA_BITS'($urandom), p0, p1);
   endtask

   // weight loads land anywhere in the image, on indexes 0 to 31, of which 18 to 31 are unused
   task automatic send_random_item();
      if ($urandom_range(0, 99) < 6)
         send_item(cv3_pkg::CMD_WEIGHT, cv3_pkg::WIDX_BITS'($urandom_range(0, 31)),
                   draw_sample(), cv3_pkg::DATA_BITS'($urandom),
                   cv3_pkg::DATA_BITS'($urandom));
      else
         send_pixel(draw_sample(), draw_sample());
   endtask

   task automatic test_weight_table();
      logic signed [cv3_pkg::DATA_BITS-1:0] wval;
      for (int i = 0; i < cv3_pkg::COEF_COUNT; i++) begin
         wval = (i % 2) ? 16'sh7fff : 16'sh8000;
         if (i == 4) wval = 16'sh0001;
         if (i == 13) wval = -16'sh0001;
         send_item(cv3_pkg::CMD_WEIGHT, cv3_pkg::WIDX_BITS'(i), wval,
                   cv3_pkg::DATA_BITS'($urandom), cv3_pkg::DATA_BITS'($urandom));
      end
      // indexes past the table must leave it untouched
      send_item(cv3_pkg::CMD_WEIGHT, cv3_pkg::WIDX_BITS'(cv3_pkg::COEF_COUNT), 16'sh3039,
                '0, '0);
      send_item(cv3_pkg::CMD_WEIGHT, {cv3_pkg::WIDX_BITS{1'b1}}, 16'sh8000, '1, '1);
   endtask

   task automatic test_border_pixels();
      send_pixel(16'sh8000, 16'sh7fff);
      send_pixel(16'sh7fff, 16'sh8000);
      send_pixel('0, '0);
      send_pixel(-16'sh0001, 16'sh0001);
      send_pixel(16'sh8000, 16'sh8000);
   endtask

   task automatic test_random_stream(input int pixel_goal);
      while (pixels_sent < pixel_goal) send_random_item();
   endtask

   task automatic test_receiver_stall();
      sender_steady = 1'b1;
      stall_left = 300;
      for (int i = 0; i < 60; i++) send_pixel(draw_sample(), draw_sample());
      sender_steady = 1'b0;
   endtask

   task automatic test_steady_stream();
      sender_steady   = 1'b1;
      receiver_steady = 1'b1;
      for (int i = 0; i < 400; i++) send_random_item();
      sender_steady   = 1'b0;
      receiver_steady = 1'b0;
   endtask

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left = stall_left - 1;
      end else begin
         rsp_bus.ready <= receiver_steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      conv_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_sums.size() == 0) begin
            $error("unexpected sum %0d at row %0d col %0d", rsp_bus.conv_sum,
                   rsp_bus.out_row, rsp_bus.out_col);
            mismatch_count++;
         end else begin
            want = pending_sums.pop_front();
            sums_checked++;
            if (rsp_bus.conv_sum !== want.conv_sum) begin
               $error("conv_sum: expected %0d, actual %0d", want.conv_sum, rsp_bus.conv_sum);
               mismatch_count++;
            end
            if (rsp_bus.out_row !== want.out_row) begin
               $error("out_row: expected %0d, actual %0d", want.out_row, rsp_bus.out_row);
               mismatch_count++;
            end
            if (rsp_bus.out_col !== want.out_col) begin
               $error("out_col: expected %0d, actual %0d", want.out_col, rsp_bus.out_col);
               mismatch_count++;
            end
            if (rsp_bus.last !== want.last) begin
               $error("last: expected %0d, actual %0d", want.last, rsp_bus.last);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d sums still pending", cycle_count,
                  pending_sums.size());
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.command      = cv3_pkg::CMD_WEIGHT;
      req_bus.weight_index = '0;
      req_bus.weight_value = '0;
      req_bus.pixel_lane0  = '0;
      req_bus.pixel_lane1  = '0;
      rsp_bus.ready        = 1'b0;
      cycle_count     = 0;
      mismatch_count  = 0;
      sums_checked    = 0;
      items_sent      = 0;
      pixels_sent     = 0;
      weights_sent    = 0;
      stall_left      = 0;
      sender_steady   = 1'b0;
      receiver_steady = 1'b0;
      clear_predictor();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_weight_table();
      test_border_pixels();
      test_random_stream(400);
      test_receiver_stall();
      test_steady_stream();
      // more random traffic with idle cycles on both sides
      test_random_stream(1680);

      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_sums.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);

      $display("sent %0d items (%0d pixels, %0d weight loads), checked %0d sums",
               items_sent, pixels_sent, weights_sent, sums_checked);
      $display("covered used and unused weight slots, border pixels, a long receiver");
      $display("stall and a gapless stretch");
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
